@@ hw/rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Operation and status codes, word width and the control group that the
// queue controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int WORD_WIDTH = 32;

   localparam logic [WORD_WIDTH-1:0] EMPTY_WORD = '1;

   typedef enum logic [1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_PUSH_REAR  = 2'd1,
      ACT_POP_FRONT  = 2'd2,
      ACT_POP_REAR   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic shift_front;   // push front: every cell takes its left neighbor
      logic shift_back;    // pop front: every cell takes its right neighbor
      logic write_rear;    // push rear: the first free cell takes the word
   } cell_ctl_type;

endpackage

@@ hw/rtl/deq_if.sv @@
// ----------------------------------------------------------------------------
// deq_if: request and response channels of the double-ended queue
// Valid/ready channels; a beat moves on a rising edge with valid and ready.
// ----------------------------------------------------------------------------
interface deq_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          action;
   logic signed [deq_pkg::WORD_WIDTH-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface deq_rsp_if #(
   parameter int OCC_WIDTH = 5
);
   logic                                  valid;
   logic                                  ready;
   logic signed [deq_pkg::WORD_WIDTH-1:0] popped_value;
   logic [1:0]                            status;
   logic [OCC_WIDTH-1:0]                  occupancy;

   modport source (output valid, output popped_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input popped_value, input status, input occupancy,
                   output ready);
endinterface

@@ hw/rtl/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell: one storage cell of the queue chain
// Holds one word; shifts from a neighbor on front operations, takes the pushed
// word on a rear push when it is the first free slot, and offers its word to
// the rear read tree when it holds the rear entry.
// ----------------------------------------------------------------------------
module deq_cell #(
   parameter int COUNT_WIDTH = 5,
   parameter int INDEX       = 0
) (
   input  logic                               clock,
   input  deq_pkg::cell_ctl_type              ctl,
   input  logic [COUNT_WIDTH-1:0]             count,
   input  logic [deq_pkg::WORD_WIDTH-1:0]     left_word,
   input  logic [deq_pkg::WORD_WIDTH-1:0]     right_word,
   input  logic [deq_pkg::WORD_WIDTH-1:0]     push_word,
   output logic [deq_pkg::WORD_WIDTH-1:0]     word,
   output logic [deq_pkg::WORD_WIDTH-1:0]     tap
);

   logic [deq_pkg::WORD_WIDTH-1:0] word_ff;
   logic [deq_pkg::WORD_WIDTH-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.shift_front) begin
         word_in = left_word;
      end else if (ctl.shift_back) begin
         word_in = right_word;
      end else if (ctl.write_rear && (count == COUNT_WIDTH'(INDEX))) begin
         word_in = push_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   assign tap  = (count == COUNT_WIDTH'(INDEX + 1)) ? word_ff : '0;

endmodule

@@ hw/rtl/deq_rear_tree.sv @@
// ----------------------------------------------------------------------------
// deq_rear_tree: registered OR tree that collects the rear word
// Only the rear cell drives a nonzero tap, so an OR over all taps yields it.
// A register sits after every third level and at the root.
// ----------------------------------------------------------------------------
module deq_rear_tree #(
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic [DEPTH-1:0][deq_pkg::WORD_WIDTH-1:0]   taps,
   output logic [deq_pkg::WORD_WIDTH-1:0]              root
);

   localparam int LEVELS = $clog2(DEPTH);
   localparam int LEAVES = 1 << LEVELS;

   logic [deq_pkg::WORD_WIDTH-1:0] node [1:2*LEAVES-1];

   for (genvar k = 1; k < 2 * LEAVES; k++) begin : g_node
      if (k >= LEAVES) begin : g_leaf
         if (k - LEAVES < DEPTH) begin : g_used
            assign node[k] = taps[k-LEAVES];
         end else begin : g_pad
            assign node[k] = '0;
         end
      end else begin : g_inner
         localparam int HEIGHT = LEVELS - ($clog2(k + 1) - 1);
         logic [deq_pkg::WORD_WIDTH-1:0] sum_in;
         assign sum_in = node[2*k] | node[2*k+1];
         if ((HEIGHT % 3 == 0) || (k == 1)) begin : g_reg
            logic [deq_pkg::WORD_WIDTH-1:0] sum_ff;
            always_ff @(posedge clock) begin
               sum_ff <= sum_in;
            end
            assign node[k] = sum_ff;
         end else begin : g_comb
            assign node[k] = sum_in;
         end
      end
   end

   assign root = node[1];

endmodule

@@ hw/rtl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of 32-bit signed words
// Push and pop at either end; one response beat per request beat.
// ----------------------------------------------------------------------------
// The words live in a row of DEPTH cells with the front entry in cell 0.
// Pushes at either end and pops at the front update the cells and load the
// response register when accepted, so such requests stream at one beat per
// cycle while the response register is free or being drained. A pop at the
// rear reads the rear cell through a registered OR tree and waits for the word
// to pass its registers; no request is taken meanwhile. A pop from an empty
// queue returns -1 with status empty, a push into a full queue is refused with
// status full, and neither changes its contents. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   deq_req_if.sink      req_bus,
   deq_rsp_if.source    rsp_bus
);

   localparam int WW         = deq_pkg::WORD_WIDTH;
   localparam int CW         = $clog2(DEPTH + 1);
   localparam int TREE_LAT   = ($clog2(DEPTH) + 2) / 3;
   localparam int LAT_WIDTH  = $clog2(TREE_LAT + 1);

   typedef enum logic [1:0] {
      ST_READY = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [LAT_WIDTH-1:0]    lat_ff, lat_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0]           rsp_word_ff, rsp_word_in;
   deq_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [CW-1:0]           rsp_occ_ff, rsp_occ_in;

   deq_pkg::cell_ctl_type   ctl;
   deq_pkg::action_type     action;
   logic                    accept;
   logic                    full;
   logic                    empty;
   logic                    load_rsp;

   logic [WW-1:0]                  cell_word [DEPTH];
   logic [DEPTH-1:0][WW-1:0]       tap_bus;
   logic [WW-1:0]                  rear_word;

   assign action  = deq_pkg::action_type'(req_bus.action);
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign req_bus.ready = (state_ff == ST_READY) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept  = req_bus.valid && req_bus.ready;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WW-1:0] left_word;
      logic [WW-1:0] right_word;
      if (i == 0) begin : g_first
         assign left_word = req_bus.value;
      end else begin : g_mid
         assign left_word = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_body
         assign right_word = cell_word[i+1];
      end
      deq_cell #(
         .COUNT_WIDTH (CW),
         .INDEX       (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .left_word  (left_word),
         .right_word (right_word),
         .push_word  (req_bus.value),
         .word       (cell_word[i]),
         .tap        (tap_bus[i])
      );
   end

   deq_rear_tree #(
      .DEPTH (DEPTH)
   ) u_rear_tree (
      .clock (clock),
      .taps  (tap_bus),
      .root  (rear_word)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lat_in        = lat_ff;
      ctl           = '0;
      load_rsp      = 1'b0;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;

      unique case (state_ff)
         ST_READY: begin
            if (accept) begin
               unique case (action)
                  deq_pkg::ACT_PUSH_FRONT,
                  deq_pkg::ACT_PUSH_REAR: begin
                     load_rsp    = 1'b1;
                     rsp_word_in = '0;
                     if (full) begin
                        rsp_status_in = deq_pkg::STATUS_FULL;
                        rsp_occ_in    = count_ff;
                     end else begin
                        ctl.shift_front = (action == deq_pkg::ACT_PUSH_FRONT);
                        ctl.write_rear  = (action == deq_pkg::ACT_PUSH_REAR);
                        count_in        = count_ff + CW'(1);
                        rsp_status_in   = deq_pkg::STATUS_OK;
                        rsp_occ_in      = count_ff + CW'(1);
                     end
                  end
                  deq_pkg::ACT_POP_FRONT: begin
                     load_rsp = 1'b1;
                     if (empty) begin
                        rsp_word_in   = deq_pkg::EMPTY_WORD;
                        rsp_status_in = deq_pkg::STATUS_EMPTY;
                        rsp_occ_in    = count_ff;
                     end else begin
                        ctl.shift_back = 1'b1;
                        count_in       = count_ff - CW'(1);
                        rsp_word_in    = cell_word[0];
                        rsp_status_in  = deq_pkg::STATUS_OK;
                        rsp_occ_in     = count_ff - CW'(1);
                     end
                  end
                  deq_pkg::ACT_POP_REAR: begin
                     if (empty) begin
                        load_rsp      = 1'b1;
                        rsp_word_in   = deq_pkg::EMPTY_WORD;
                        rsp_status_in = deq_pkg::STATUS_EMPTY;
                        rsp_occ_in    = count_ff;
                     end else begin
                        state_in = ST_DRAIN;
                        lat_in   = LAT_WIDTH'(TREE_LAT);
                     end
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            lat_in = lat_ff - LAT_WIDTH'(1);
            if (lat_ff == LAT_WIDTH'(1)) begin
               // rear word has settled through the tree
               state_in      = ST_READY;
               load_rsp      = 1'b1;
               count_in      = count_ff - CW'(1);
               rsp_word_in   = rear_word;
               rsp_status_in = deq_pkg::STATUS_OK;
               rsp_occ_in    = count_ff - CW'(1);
            end
         end
         default: begin
            state_in = ST_READY;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READY;
         count_ff     <= '0;
         lat_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lat_ff       <= lat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.popped_value = rsp_word_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.occupancy    = rsp_occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("occupancy above depth");

   a_full_push_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && full && (action == deq_pkg::ACT_PUSH_FRONT ||
                          action == deq_pkg::ACT_PUSH_REAR))
      |=> (count_ff == $past(count_ff)) && (rsp_status_ff == deq_pkg::STATUS_FULL))
      else $error("refused push changed occupancy");

   a_drain_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && lat_ff == LAT_WIDTH'(1))
      |=> rsp_valid_ff && (count_ff == $past(count_ff) - CW'(1))
          && (rsp_status_ff == deq_pkg::STATUS_OK))
      else $error("rear pop did not complete");

endmodule
